[rtl/csia_pkg.sv]
// Shared types and constants of the checked signed integer ALU.
package csia_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned FIELD_W  = 64;

  typedef enum logic [OP_W-1:0] {
    OP_ABS = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_REM = 3'd5,
    OP_NEG = 3'd6
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  // Control that travels down the cell chain beside the data.
  typedef struct packed {
    opcode_t op;
    logic    sa;
    logic    sb;
    logic    bzero;
    status_t st;
  } ctl_t;

endpackage

[rtl/csia_if.sv]
// Valid/ready channel interfaces for operation requests and results.
interface csia_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [csia_pkg::OP_W-1:0]      opcode;
  logic signed [csia_pkg::FIELD_W-1:0]   operand_a;
  logic signed [csia_pkg::FIELD_W-1:0]   operand_b;

  modport source (output valid, output opcode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input opcode, input operand_a, input operand_b,
                  output ready);
endinterface

interface csia_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [csia_pkg::FIELD_W-1:0]   result_value;
  logic        [csia_pkg::ST_W-1:0]      status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

[rtl/checked_signed_integer_alu_unit.sv]
// Top level of the checked signed integer ALU: decode, cell chain and result stage.
// The unit accepts one operation transfer per clock cycle while the consumer does not
// stall, and returns one result transfer for each, in order. Every item, whatever its
// opcode, passes through the same pipeline of DATA_WIDTH + 2 stages: a decode stage, a
// chain of DATA_WIDTH identical cells that each retire one bit of the multiply
// (shift-add) and of the divide (restoring, remainder kept), and a result stage that is
// the output register. The whole pipeline advances when the output register is empty
// or being taken, so in_ch.ready follows out_ch.ready; while the consumer stalls, no
// stage moves. Status is 0 for ok, 1 for overflow and 2 for divide by zero; on any
// error the result is zero. Only the low DATA_WIDTH bits of each operand are used,
// and the result is sign-extended to 64 bits.
module checked_signed_integer_alu_unit #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  csia_in_if.sink      in_ch,
  csia_out_if.source   out_ch
);
  import csia_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  logic             adv;
  logic             v      [0:W];
  ctl_t             c      [0:W];
  logic [W-1:0]     ma     [0:W];
  logic [W-1:0]     mb     [0:W];
  logic [W-1:0]     simple [0:W];
  logic [2*W-1:0]   acc    [0:W];
  logic [W-1:0]     q      [0:W];
  logic [W-1:0]     rem    [0:W];
  logic             out_valid;

  // Advance whenever the output register can hand over or is empty.
  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = out_valid;

  csia_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .opcode   (in_ch.opcode),
    .a_in     (in_ch.operand_a),
    .b_in     (in_ch.operand_b),
    .valid_r  (v[0]),
    .ctl_r    (c[0]),
    .ma_r     (ma[0]),
    .mb_r     (mb[0]),
    .simple_r (simple[0])
  );

  // The accumulators of the chain start from zero at its head.
  assign acc[0] = '0;
  assign q[0]   = '0;
  assign rem[0] = '0;

  // Cell k handles operand bit W-1-k, most significant first.
  for (genvar k = 0; k < W; k++) begin : g_cell
    csia_cell #(.W(W), .IDX(W - 1 - k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .valid_i  (v[k]),
      .ctl_i    (c[k]),
      .ma_i     (ma[k]),
      .mb_i     (mb[k]),
      .simple_i (simple[k]),
      .acc_i    (acc[k]),
      .q_i      (q[k]),
      .rem_i    (rem[k]),
      .valid_r  (v[k+1]),
      .ctl_r    (c[k+1]),
      .ma_r     (ma[k+1]),
      .mb_r     (mb[k+1]),
      .simple_r (simple[k+1]),
      .acc_r    (acc[k+1]),
      .q_r      (q[k+1]),
      .rem_r    (rem[k+1])
    );
  end

  csia_back #(.W(W)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .valid_i  (v[W]),
    .ctl_i    (c[W]),
    .simple_i (simple[W]),
    .acc_i    (acc[W]),
    .q_i      (q[W]),
    .rem_i    (rem[W]),
    .valid_r  (out_valid),
    .result_r (out_ch.result_value),
    .status_r (out_ch.status)
  );
endmodule

[rtl/csia_front.sv]
// Operand decode stage: magnitudes, add, subtract, abs and negate.
module csia_front #(
  parameter int unsigned W = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic [csia_pkg::OP_W-1:0]       opcode,
  input  logic [csia_pkg::FIELD_W-1:0]    a_in,
  input  logic [csia_pkg::FIELD_W-1:0]    b_in,
  output logic                            valid_r,
  output csia_pkg::ctl_t                  ctl_r,
  output logic [W-1:0]                    ma_r,
  output logic [W-1:0]                    mb_r,
  output logic [W-1:0]                    simple_r
);
  import csia_pkg::*;

  logic [W-1:0] a, b, lim, ma, mb, sum, diff, nega, simple_nxt;
  logic         sa, sb;
  ctl_t         ctl_nxt;

  assign a    = a_in[W-1:0];
  assign b    = b_in[W-1:0];
  assign sa   = a[W-1];
  assign sb   = b[W-1];
  assign lim  = {1'b1, {(W-1){1'b0}}};
  assign nega = '0 - a;
  assign ma   = sa ? nega : a;
  assign mb   = sb ? ('0 - b) : b;
  assign sum  = a + b;
  assign diff = a - b;

  always_comb begin
    ctl_nxt.op    = opcode_t'(opcode);
    ctl_nxt.sa    = sa;
    ctl_nxt.sb    = sb;
    ctl_nxt.bzero = (b == '0);
    ctl_nxt.st    = ST_OK;
    simple_nxt    = '0;
    case (opcode_t'(opcode))
      OP_ABS: begin
        if (a == lim) ctl_nxt.st = ST_OVF;
        else simple_nxt = ma;
      end
      OP_NEG: begin
        if (a == lim) ctl_nxt.st = ST_OVF;
        else simple_nxt = nega;
      end
      OP_ADD: begin
        simple_nxt = sum;
        if (sa == sb && sum[W-1] != sa) ctl_nxt.st = ST_OVF;
      end
      OP_SUB: begin
        simple_nxt = diff;
        if (sa != sb && diff[W-1] != sa) ctl_nxt.st = ST_OVF;
      end
      default: begin
        simple_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r    <= ctl_nxt;
      ma_r     <= ma;
      mb_r     <= mb;
      simple_r <= simple_nxt;
    end
  end
endmodule

[rtl/csia_cell.sv]
// One bit step of the shift-add multiplier and restoring divider.
module csia_cell #(
  parameter int unsigned W   = 64,
  parameter int unsigned IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               valid_i,
  input  csia_pkg::ctl_t     ctl_i,
  input  logic [W-1:0]       ma_i,
  input  logic [W-1:0]       mb_i,
  input  logic [W-1:0]       simple_i,
  input  logic [2*W-1:0]     acc_i,
  input  logic [W-1:0]       q_i,
  input  logic [W-1:0]       rem_i,
  output logic               valid_r,
  output csia_pkg::ctl_t     ctl_r,
  output logic [W-1:0]       ma_r,
  output logic [W-1:0]       mb_r,
  output logic [W-1:0]       simple_r,
  output logic [2*W-1:0]     acc_r,
  output logic [W-1:0]       q_r,
  output logic [W-1:0]       rem_r
);
  logic [2*W-1:0] acc_nxt;
  logic [W:0]     trial, diff;
  logic           qbit;
  logic [W-1:0]   rem_nxt;

  // The multiplier adds the multiplicand magnitude for each set multiplier bit, MSB first.
  assign acc_nxt = {acc_i[2*W-2:0], 1'b0} +
                   (mb_i[IDX] ? {{W{1'b0}}, ma_i} : {(2*W){1'b0}});
  assign trial   = {rem_i, ma_i[IDX]};
  assign diff    = trial - {1'b0, mb_i};
  assign qbit    = ~diff[W];
  assign rem_nxt = qbit ? diff[W-1:0] : trial[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r    <= ctl_i;
      ma_r     <= ma_i;
      mb_r     <= mb_i;
      simple_r <= simple_i;
      acc_r    <= acc_nxt;
      q_r      <= {q_i[W-2:0], qbit};
      rem_r    <= rem_nxt;
    end
  end
endmodule

[rtl/csia_back.sv]
// Result stage: overflow and divide-by-zero checks, sign restore and the output register.
module csia_back #(
  parameter int unsigned W = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            valid_i,
  input  csia_pkg::ctl_t                  ctl_i,
  input  logic [W-1:0]                    simple_i,
  input  logic [2*W-1:0]                  acc_i,
  input  logic [W-1:0]                    q_i,
  input  logic [W-1:0]                    rem_i,
  output logic                            valid_r,
  output logic [csia_pkg::FIELD_W-1:0]    result_r,
  output logic [csia_pkg::ST_W-1:0]       status_r
);
  import csia_pkg::*;

  logic [W-1:0] lim, hi, lo, r;
  logic         neg;
  status_t      st;

  assign lim = {1'b1, {(W-1){1'b0}}};
  assign hi  = acc_i[2*W-1:W];
  assign lo  = acc_i[W-1:0];
  assign neg = ctl_i.sa ^ ctl_i.sb;

  always_comb begin
    st = ST_OK;
    r  = '0;
    case (ctl_i.op)
      OP_MUL: begin
        if (hi != '0 || lo > (neg ? lim : lim - 1'b1)) st = ST_OVF;
        else r = neg ? ('0 - lo) : lo;
      end
      OP_DIV: begin
        if (ctl_i.bzero) st = ST_DIV0;
        else if (!neg && q_i[W-1]) st = ST_OVF;
        else r = neg ? ('0 - q_i) : q_i;
      end
      OP_REM: begin
        if (ctl_i.bzero) st = ST_DIV0;
        else r = ctl_i.sa ? ('0 - rem_i) : rem_i;
      end
      default: begin
        st = ctl_i.st;
        r  = simple_i;
      end
    endcase
    if (st != ST_OK) r = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_r <= FIELD_W'($signed(r));
      status_r <= st;
    end
  end
endmodule

[verif/tb.sv]
// Self-checking testbench for the checked signed integer ALU unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csia_pkg::*;

  localparam int unsigned DW = 64;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = DW + 10;

  typedef struct packed {
    logic signed [FIELD_W-1:0] value;
    status_t                   st;
  } alu_result_t;

  localparam logic [63:0] MIN_V = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_V = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_ONE = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  csia_in_if  op_ch ();
  csia_out_if res_ch ();

  checked_signed_integer_alu_unit #(.DATA_WIDTH(DW)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (op_ch.sink),
    .out_ch (res_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Results still owed by the unit, oldest first.
  alu_result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned ops_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned op_counts[8];
  bit          timed_out = 1'b0;

  // Gap length: mostly zero or short, occasionally long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [63:0] magnitude_of(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Computes what the unit must return for one operation transfer. With a
  // full 64-bit data width no narrowing or sign extension is needed.
  function automatic alu_result_t compute_alu(logic [2:0] op, logic [63:0] a,
                                              logic [63:0] b);
    alu_result_t   res;
    logic [63:0]   r;
    logic [127:0]  prod;
    logic [63:0]   quo;
    logic [63:0]   rem;
    logic          neg;
    status_t       st;
    r = '0;
    st = ST_OK;
    neg = a[63] ^ b[63];
    case (op)
      OP_ABS: begin
        if (a == MIN_V) st = ST_OVF;
        else r = magnitude_of(a);
      end
      OP_NEG: begin
        if (a == MIN_V) st = ST_OVF;
        else r = -a;
      end
      OP_ADD: begin
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) st = ST_OVF;
      end
      OP_SUB: begin
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) st = ST_OVF;
      end
      OP_MUL: begin
        prod = {64'd0, magnitude_of(a)} * {64'd0, magnitude_of(b)};
        // A negative product may reach the minimum value; a positive one may not.
        if (prod[127:64] != 0 || prod[63:0] > (neg ? MIN_V : MAX_V)) st = ST_OVF;
        else r = neg ? -prod[63:0] : prod[63:0];
      end
      OP_DIV, OP_REM: begin
        if (b == 0) begin
          st = ST_DIV0;
        end else begin
          quo = magnitude_of(a) / magnitude_of(b);
          rem = magnitude_of(a) % magnitude_of(b);
          if (op == OP_DIV) begin
            // Only the minimum divided by -1 yields a quotient too large.
            if (!neg && quo > MAX_V) st = ST_OVF;
            else r = neg ? -quo : quo;
          end else begin
            r = a[63] ? -rem : rem;
          end
        end
      end
      default: r = '0;
    endcase
    if (st != ST_OK) r = '0;
    res.value = r;
    res.st = st;
    return res;
  endfunction

  // Presents one operation after a random gap and holds it until the transfer.
  // Valid stays high into the next operation when there is no gap.
  task automatic send_op(logic [2:0] op, logic [63:0] a, logic [63:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      op_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_ch.valid     <= 1'b1;
    op_ch.opcode    <= op;
    op_ch.operand_a <= a;
    op_ch.operand_b <= b;
    pending_results.push_back(compute_alu(op, a, b));
    op_counts[op]++;
    do @(posedge clk); while (!op_ch.ready);
    ops_sent++;
  endtask

  // Random operand biased toward boundaries and small magnitudes.
  function automatic logic [63:0] rand_operand();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return MIN_V;
    if (roll < 17) return MAX_V;
    if (roll < 24) return NEG_ONE;
    if (roll < 30) return 64'd0;
    if (roll < 36) return 64'd1;
    if (roll < 55) return {{48{1'($urandom_range(1))}}, 16'($urandom)};
    if (roll < 70) return {{32{1'($urandom_range(1))}}, 32'($urandom)};
    return {32'($urandom), 32'($urandom)};
  endfunction

  task automatic test_unary_ops();
    logic [63:0] vals[6];
    vals = '{MIN_V, MAX_V, NEG_ONE, 64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFE};
    foreach (vals[i]) begin
      send_op(OP_ABS, vals[i], ~vals[i]);
      send_op(OP_NEG, vals[i], vals[i]);
    end
  endtask

  task automatic test_binary_edges();
    send_op(OP_ADD, MAX_V, 64'd1);
    send_op(OP_ADD, MIN_V, NEG_ONE);
    send_op(OP_SUB, MIN_V, 64'd1);
    send_op(OP_SUB, MAX_V, NEG_ONE);
    send_op(OP_MUL, MIN_V, 64'd1);
    send_op(OP_MUL, MIN_V, NEG_ONE);
    send_op(OP_MUL, 64'h0000_0001_0000_0000, 64'hFFFF_FFFF_8000_0000);
    send_op(OP_DIV, MIN_V, NEG_ONE);
    send_op(OP_REM, MIN_V, NEG_ONE);
    send_op(OP_DIV, 64'd7, 64'd0);
    send_op(OP_REM, MIN_V, 64'd0);
    send_op(OP_DIV, -64'sd7, 64'd2);
    send_op(OP_REM, -64'sd7, 64'd2);
    // The unused opcode must come back as zero with an ok status.
    send_op(3'd7, MAX_V, MIN_V);
  endtask

  task automatic test_random_ops(int unsigned count);
    logic [2:0]  op;
    logic [63:0] a;
    logic [63:0] b;
    repeat (count) begin
      op = $urandom_range(7) == 7 ? 3'd7 : 3'($urandom_range(6));
      a = $urandom_range(3) == 0 ? {32'($urandom), 32'($urandom)} : rand_operand();
      b = $urandom_range(3) == 0 ? {32'($urandom), 32'($urandom)} : rand_operand();
      send_op(op, a, b);
    end
  endtask

  // Consumer side: random stalls, with no-stall stretches now and then.
  initial begin
    int unsigned burst;
    res_ch.ready <= 1'b0;
    burst = 0;
    forever begin
      @(posedge clk);
      if (burst > 0) begin
        burst--;
        res_ch.ready <= 1'b1;
      end else if ($urandom_range(19) == 0) begin
        burst = $urandom_range(60, 20);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= (pick_gap() == 0);
      end
    end
  end

  // Compares each result transfer with the oldest outstanding prediction.
  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result value=%h status=%0d",
                   res_ch.result_value, res_ch.status);
      end else begin
        want = pending_results.pop_front();
        if (res_ch.result_value !== want.value || res_ch.status !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d expected value=%h status=%0d, got value=%h status=%0d",
                     results_seen, want.value, want.st, res_ch.result_value,
                     res_ch.status);
        end
      end
    end
  end

  // Ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: watchdog expired with %0d results outstanding",
               pending_results.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    op_ch.valid     <= 1'b0;
    op_ch.opcode    <= '0;
    op_ch.operand_a <= '0;
    op_ch.operand_b <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unary_ops();
    test_binary_edges();
    test_random_ops(480);
    op_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d operations and checked %0d results.", ops_sent, results_seen);
    $display("Per opcode: abs %0d add %0d sub %0d mul %0d div %0d rem %0d neg %0d unused %0d",
             op_counts[0], op_counts[1], op_counts[2], op_counts[3],
             op_counts[4], op_counts[5], op_counts[6], op_counts[7]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[checked_signed_integer_alu_unit.f]
rtl/csia_pkg.sv
rtl/csia_if.sv
rtl/csia_front.sv
rtl/csia_cell.sv
rtl/csia_back.sv
rtl/checked_signed_integer_alu_unit.sv
verif/tb.sv
